>>> design/grpm_pkg.sv
// ----------------------------------------------------------------------------
// grpm_pkg
// Shared types and constants of the gain ramp and peak meter block.
// ----------------------------------------------------------------------------
package grpm_pkg;

   // Command codes on the request channel
   localparam logic [2:0] CMD_SAMPLE = 3'd0;
   localparam logic [2:0] CMD_END    = 3'd1;
   localparam logic [2:0] CMD_PEAK   = 3'd2;
   localparam logic [2:0] CMD_LOAD   = 3'd3;
   localparam logic [2:0] CMD_FADE   = 3'd4;

   // Register indexes on the csr channel
   localparam logic [2:0] CSR_GAIN_LEFT   = 3'd0;
   localparam logic [2:0] CSR_GAIN_RIGHT  = 3'd1;
   localparam logic [2:0] CSR_GAIN_SINGLE = 3'd2;
   localparam logic [2:0] CSR_CHAN_COUNT  = 3'd3;
   localparam logic [2:0] CSR_BLOCK_LOG2  = 3'd4;

   localparam int CMD_W     = 3;
   localparam int CHAN_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int GAIN_W    = 16;
   localparam int COUNT_W   = 4;
   localparam int POS_W     = 13;
   localparam int FRAC_BITS = 14;

   localparam logic [GAIN_W-1:0]  GAIN_UNITY      = 16'd16384;
   localparam logic [COUNT_W-1:0] CHAN_COUNT_RST  = 4'd2;
   localparam logic [COUNT_W-1:0] BLOCK_LOG2_RST  = 4'd8;
   localparam logic [COUNT_W-1:0] RAMP_LOG2_MAX   = 4'd12;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NONE,
      OP_SAMPLE,
      OP_END,
      OP_PEAK,
      OP_LOAD,
      OP_FADE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAN_W-1:0]   channel;
   } item_ctl_type;

   // Effective configuration seen by front and back
   typedef struct packed {
      logic [GAIN_W-1:0]   gain_left;
      logic [GAIN_W-1:0]   gain_right;
      logic [GAIN_W-1:0]   gain_single;
      logic [COUNT_W-1:0]  used;
      logic [COUNT_W-1:0]  ramp_log2;
   } cfg_type;

endpackage

>>> design/grpm_csr.sv
// ----------------------------------------------------------------------------
// grpm_csr
// Configuration registers; presents the clamped channel count and ramp length.
// ----------------------------------------------------------------------------
module grpm_csr #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [grpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [grpm_pkg::GAIN_W-1:0]   csr_data,
   output grpm_pkg::cfg_type             cfg
);
   import grpm_pkg::*;

   logic [GAIN_W-1:0]  gain_left_ff, gain_right_ff, gain_single_ff;
   logic [COUNT_W-1:0] chan_count_ff, block_log2_ff;

   assign csr_ready = 1'b1;

   // Take a write on every transfer; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_left_ff   <= GAIN_UNITY;
         gain_right_ff  <= GAIN_UNITY;
         gain_single_ff <= GAIN_UNITY;
         chan_count_ff  <= CHAN_COUNT_RST;
         block_log2_ff  <= BLOCK_LOG2_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_LEFT:   gain_left_ff   <= csr_data;
            CSR_GAIN_RIGHT:  gain_right_ff  <= csr_data;
            CSR_GAIN_SINGLE: gain_single_ff <= csr_data;
            CSR_CHAN_COUNT:  chan_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_BLOCK_LOG2:  block_log2_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp channel count and ramp length
   always_comb begin
      cfg.gain_left   = gain_left_ff;
      cfg.gain_right  = gain_right_ff;
      cfg.gain_single = gain_single_ff;
      cfg.used        = (int'(chan_count_ff) > MAX_CHANNELS) ? COUNT_W'(MAX_CHANNELS)
                                                             : chan_count_ff;
      cfg.ramp_log2   = (block_log2_ff > RAMP_LOG2_MAX) ? RAMP_LOG2_MAX : block_log2_ff;
   end

endmodule

>>> design/grpm_front.sv
// ----------------------------------------------------------------------------
// grpm_front
// Request intake: classifies each command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module grpm_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  grpm_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [grpm_pkg::CMD_W-1:0]        req_cmd,
   input  logic [grpm_pkg::CHAN_W-1:0]       req_channel,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_in,
   output logic                              q_valid,
   input  logic                              q_ready,
   output grpm_pkg::item_ctl_type            q_ctl,
   output logic signed [SAMPLE_BITS-1:0]     q_sample
);
   import grpm_pkg::*;

   localparam int DEPTH = 2;

   item_ctl_type               ctl_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] smp_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop, chan_ok;
   item_ctl_type cls;

   // Classify; channel commands outside the used range become OP_NONE and return a zero result
   always_comb begin
      chan_ok     = ({1'b0, req_channel} < cfg.used);
      cls.channel = req_channel;
      unique case (req_cmd)
         CMD_SAMPLE: cls.op = chan_ok ? OP_SAMPLE : OP_NONE;
         CMD_END:    cls.op = OP_END;
         CMD_PEAK:   cls.op = chan_ok ? OP_PEAK : OP_NONE;
         CMD_LOAD:   cls.op = OP_LOAD;
         CMD_FADE:   cls.op = OP_FADE;
         default:    cls.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'(DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign q_ctl     = ctl_ff[rd_ptr_ff];
   assign q_sample  = smp_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff] <= cls;
         smp_ff[wr_ptr_ff] <= req_sample_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/grpm_back.sv
// ----------------------------------------------------------------------------
// grpm_back
// Execution: ramp gain, scaling with rounding and saturation, peak hold,
// gain loads and fades, and the result register.
// ----------------------------------------------------------------------------
module grpm_back #(
   parameter int MAX_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  grpm_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  grpm_pkg::item_ctl_type        q_ctl,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_peak_out
);
   import grpm_pkg::*;

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PRD_W = GAIN_W + POS_W;          // gain times ramp weight
   localparam int SUM_W = PRD_W + 1;
   localparam int MUL_W = SAMPLE_BITS + GAIN_W + 1; // sample times signed gain
   localparam int TW    = MUL_W + 1;

   localparam logic signed [TW-1:0] SAT_HI = {{(TW-SAMPLE_BITS+1){1'b0}},
                                             {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [TW-1:0] SAT_LO = {{(TW-SAMPLE_BITS+1){1'b1}},
                                             {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [TW-1:0] ROUND_HALF = TW'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [1:0] {S_IDLE, S_GAIN, S_SCALE, S_OUT} state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic in_block_ff, in_block_in, ramping_ff, ramping_in, armed_ff, armed_in;

   logic [GAIN_W-1:0] cur_ff  [MAX_CHANNELS], cur_in  [MAX_CHANNELS];
   logic [GAIN_W-1:0] prev_ff [MAX_CHANNELS], prev_in [MAX_CHANNELS];
   logic [POS_W-1:0]  pos_ff  [MAX_CHANNELS], pos_in  [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] peak_ff [MAX_CHANNELS], peak_in [MAX_CHANNELS];

   logic [PRD_W-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [GAIN_W-1:0] gcur_ff, gcur_in;
   logic signed [MUL_W-1:0] mul_ff, mul_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in, rsp_peak_ff, rsp_peak_in;

   logic [POS_W-1:0]  n_len, p_eff;
   logic [SUM_W-1:0]  wsum;
   logic [GAIN_W-1:0] g_eff;
   logic signed [TW-1:0] t_rnd, q_shr;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic [COUNT_W-1:0] paired;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_peak_out   = rsp_peak_ff;

   // Ramp length, clamped position, weighted gain and rounded output
   always_comb begin
      n_len  = POS_W'(1) << cfg.ramp_log2;
      p_eff  = (pos_ff[ch_ff] > n_len) ? n_len : pos_ff[ch_ff];
      wsum   = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff);
      g_eff  = ramping_ff ? GAIN_W'(wsum >> cfg.ramp_log2) : gcur_ff;
      t_rnd  = TW'(mul_ff) + ROUND_HALF;
      q_shr  = t_rnd >>> FRAC_BITS;
      if (q_shr > SAT_HI)      y_sat = SAT_HI[SAMPLE_BITS-1:0];
      else if (q_shr < SAT_LO) y_sat = SAT_LO[SAMPLE_BITS-1:0];
      else                     y_sat = q_shr[SAMPLE_BITS-1:0];
      paired = {cfg.used[COUNT_W-1:1], 1'b0};
   end

   // Sequence one item through gain, scale and result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      in_block_in   = in_block_ff;
      ramping_in    = ramping_ff;
      armed_in      = armed_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      peak_in       = peak_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      gcur_in       = gcur_ff;
      mul_in        = mul_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      q_ready       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_ready = 1'b1;
               op_in   = q_ctl.op;
               ch_in   = CH_W'(q_ctl.channel);
               x_in    = q_sample;
               if (q_ctl.op == OP_SAMPLE) begin
                  state_in = S_GAIN;
                  // First sample of a block latches the armed ramp
                  if (!in_block_ff) begin
                     in_block_in = 1'b1;
                     ramping_in  = armed_ff;
                     armed_in    = 1'b0;
                     for (int i = 0; i < MAX_CHANNELS; i++) pos_in[i] = '0;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_GAIN: begin
            prod_a_in = PRD_W'(prev_ff[ch_ff]) * PRD_W'(n_len - p_eff);
            prod_b_in = PRD_W'(cur_ff[ch_ff]) * PRD_W'(p_eff);
            gcur_in   = cur_ff[ch_ff];
            if (ramping_ff) begin
               pos_in[ch_ff] = (p_eff < n_len) ? p_eff + POS_W'(1) : p_eff;
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            mul_in   = $signed(x_ff) * $signed({1'b0, g_eff});
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_peak_in   = '0;
               state_in      = S_IDLE;
               case (op_ff)
                  OP_SAMPLE: begin
                     rsp_sample_in = y_sat;
                     if (y_sat > peak_ff[ch_ff]) peak_in[ch_ff] = y_sat;
                  end
                  OP_END: in_block_in = 1'b0;
                  OP_PEAK: begin
                     rsp_peak_in    = peak_ff[ch_ff];
                     peak_in[ch_ff] = '0;
                  end
                  OP_LOAD: begin
                     for (int i = 0; i < MAX_CHANNELS; i++) begin
                        if (i < int'(cfg.used)) begin
                           prev_in[i] = cur_ff[i];
                           if (i < int'(paired))
                              cur_in[i] = i[0] ? cfg.gain_right : cfg.gain_left;
                           else
                              cur_in[i] = cfg.gain_single;
                        end
                     end
                     armed_in = 1'b1;
                  end
                  OP_FADE: begin
                     for (int i = 0; i < MAX_CHANNELS; i++) prev_in[i] = '0;
                     armed_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ch_ff         <= ch_in;
      x_ff          <= x_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      gcur_ff       <= gcur_in;
      mul_ff        <= mul_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_peak_ff   <= rsp_peak_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         in_block_ff  <= 1'b0;
         ramping_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            cur_ff[i]  <= '0;
            prev_ff[i] <= '0;
            pos_ff[i]  <= '0;
            peak_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         in_block_ff  <= in_block_in;
         ramping_ff   <= ramping_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         peak_ff      <= peak_in;
      end
   end

endmodule

>>> design/gain_ramp_peak_meter.sv
// Flow: each request passes the two-entry request queue, then the back-end
//   sequencer: gain multiply, scale multiply, round and store for a sample,
//   store alone for any other command. The sequencer starts a new item only
//   once the last is in the result register, and a stalled result holds it.
// Reset: synchronous; clears gains, peaks, ramp state and queue, and loads
//   the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// gain_ramp_peak_meter
// Multichannel gain stage with linear gain ramps and a per-channel peak meter.
// ----------------------------------------------------------------------------
module gain_ramp_peak_meter #(
   parameter int MAX_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [grpm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [grpm_pkg::CHAN_W-1:0]    req_channel,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]  rsp_sample_out,
   output logic signed [SAMPLE_BITS-1:0]  rsp_peak_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [grpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [grpm_pkg::GAIN_W-1:0]    csr_data
);
   import grpm_pkg::*;

   cfg_type      cfg;
   logic         q_valid, q_ready;
   item_ctl_type q_ctl;
   logic signed [SAMPLE_BITS-1:0] q_sample;

   grpm_csr #(.MAX_CHANNELS(MAX_CHANNELS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   grpm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_channel   (req_channel),
      .req_sample_in (req_sample_in),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_ctl         (q_ctl),
      .q_sample      (q_sample)
   );

   grpm_back #(.MAX_CHANNELS(MAX_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_ctl          (q_ctl),
      .q_sample       (q_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_peak_out   (rsp_peak_out)
   );

endmodule

>>> design/grpm_checker.sv
// ----------------------------------------------------------------------------
// grpm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module grpm_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_peak_out
);

   // Reset empties the result register
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_peak_out))
      else $error("stalled result changed");

   // A result carries a sample or a peak, never both
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out == '0) || (rsp_peak_out == '0))
      else $error("sample and peak both nonzero");

   // A held peak starts at zero and never goes negative
   a_peak_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_peak_out[SAMPLE_BITS-1])
      else $error("negative peak reported");

endmodule

bind gain_ramp_peak_meter grpm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_grpm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_peak_out   (rsp_peak_out)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gain ramp and peak meter. A predictor holds its
// own copy of the gains, ramp positions, peaks and registers, and works out
// the output of every accepted request. A directed pass covers the sample
// extremes, all commands, reserved codes, unused channels, channel counts and
// ramp lengths past their limits. Back-pressure and random block traffic
// follow.
// ----------------------------------------------------------------------------
module testbench;
   import grpm_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int CLK_PERIOD     = 2 * CLK_HALF;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_CH         = 8;
   localparam int SW             = 24;
   localparam int RANDOM_ITEMS   = 1950;

   // Codes with no meaning to the block
   localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [SW-1:0] sample_out;
      logic signed [SW-1:0] peak_out;
   } meter_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd = CMD_SAMPLE;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic signed [SW-1:0]  req_sample_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [SW-1:0]  rsp_sample_out;
   logic signed [SW-1:0]  rsp_peak_out;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GAIN_LEFT;
   logic [GAIN_W-1:0]     csr_data = '0;

   // Register copy, reset values
   logic [GAIN_W-1:0]  cfg_left   = GAIN_UNITY;
   logic [GAIN_W-1:0]  cfg_right  = GAIN_UNITY;
   logic [GAIN_W-1:0]  cfg_single = GAIN_UNITY;
   logic [COUNT_W-1:0] cfg_count  = CHAN_COUNT_RST;
   logic [COUNT_W-1:0] cfg_log2   = BLOCK_LOG2_RST;

   // Gain stage and meter state, all cleared by reset
   logic [GAIN_W-1:0]    gain_now [MAX_CH] = '{default: '0};
   logic [GAIN_W-1:0]    gain_was [MAX_CH] = '{default: '0};
   logic signed [SW-1:0] held_peak[MAX_CH] = '{default: '0};
   int unsigned          ramp_count[MAX_CH] = '{default: 0};
   bit                   ramp_pending = 1'b0;
   bit                   block_open   = 1'b0;
   bit                   block_ramps  = 1'b0;

   meter_out_type  awaited_outputs[$];
   meter_out_type  oldest;
   int unsigned failures        = 0;
   int unsigned items_sent      = 0;
   int unsigned outputs_checked = 0;
   int unsigned csr_writes      = 0;
   int unsigned req_max_gap     = 4;
   int unsigned rsp_max_stall   = 4;
   int unsigned hold_request    = 0;

   gain_ramp_peak_meter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_peak_out   (rsp_peak_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic int unsigned channels_in_use();
      return (cfg_count > MAX_CH) ? MAX_CH : int'(cfg_count);
   endfunction

   // Advance the gain stage by one request and return its output
   function automatic meter_out_type scale_and_meter(logic [CMD_W-1:0] cmd,
                                                     logic [CHAN_W-1:0] ch,
                                                     logic signed [SW-1:0] smp);
      meter_out_type        r;
      int unsigned          used, lg, n, p, g, paired;
      longint               acc;
      logic signed [SW-1:0] y;
      r = '0;
      used = channels_in_use();
      if (cmd == CMD_SAMPLE && ch < used) begin
         lg = (cfg_log2 > RAMP_LOG2_MAX) ? int'(RAMP_LOG2_MAX) : int'(cfg_log2);
         n = 1 << lg;
         // first sample of a block decides whether it ramps
         if (!block_open) begin
            block_open = 1'b1;
            block_ramps = ramp_pending;
            ramp_pending = 1'b0;
            foreach (ramp_count[i]) ramp_count[i] = 0;
         end
         if (block_ramps) begin
            p = ramp_count[ch];
            if (p > n) p = n;
            g = (32'(gain_was[ch]) * (n - p) + 32'(gain_now[ch]) * p) >> lg;
            if (p < n) p++;
            ramp_count[ch] = p;
         end else begin
            g = gain_now[ch];
         end
         // round half up over 2^14, then saturate
         acc = longint'(smp) * longint'(g) + 64'sd8192;
         acc = acc >>> FRAC_BITS;
         if (acc > longint'(SAMPLE_MAX)) acc = longint'(SAMPLE_MAX);
         if (acc < longint'(SAMPLE_MIN)) acc = longint'(SAMPLE_MIN);
         y = acc[SW-1:0];
         if (y > held_peak[ch]) held_peak[ch] = y;
         r.sample_out = y;
      end else if (cmd == CMD_END) begin
         block_open = 1'b0;
      end else if (cmd == CMD_PEAK && ch < used) begin
         r.peak_out = held_peak[ch];
         held_peak[ch] = '0;
      end else if (cmd == CMD_LOAD) begin
         paired = used - (used % 2);
         for (int i = 0; i < used; i++) begin
            gain_was[i] = gain_now[i];
            if (i < paired) gain_now[i] = (i % 2) ? cfg_right : cfg_left;
            else gain_now[i] = cfg_single;
         end
         ramp_pending = 1'b1;
      end else if (cmd == CMD_FADE) begin
         foreach (gain_was[i]) gain_was[i] = '0;
         ramp_pending = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [SW-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return 24'($signed($urandom_range(0, 511)) - 256);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return GAIN_UNITY;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request after a random gap; leave valid high on return
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                            logic signed [SW-1:0] smp);
      int unsigned gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_channel   <= ch;
      req_sample_in <= smp;
      do @(posedge clock); while (!req_ready);
      if (!(cmd > CMD_FADE ||
            ((cmd == CMD_SAMPLE || cmd == CMD_PEAK) && ch >= channels_in_use())))
         items_sent++;
      awaited_outputs.push_back(scale_and_meter(cmd, ch, smp));
   endtask

   // Stop offering and wait for every output to come back
   task automatic wait_meter_idle();
      req_valid <= 1'b0;
      wait (awaited_outputs.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // Write one register; valid stays high for a following write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_GAIN_LEFT:   cfg_left   = data;
         CSR_GAIN_RIGHT:  cfg_right  = data;
         CSR_GAIN_SINGLE: cfg_single = data;
         CSR_CHAN_COUNT:  cfg_count  = data[COUNT_W-1:0];
         CSR_BLOCK_LOG2:  cfg_log2   = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_meter(logic [GAIN_W-1:0] gl, logic [GAIN_W-1:0] gr,
                                  logic [GAIN_W-1:0] gs, logic [COUNT_W-1:0] cnt,
                                  logic [COUNT_W-1:0] lg2);
      write_csr(CSR_GAIN_LEFT, gl);
      write_csr(CSR_GAIN_RIGHT, gr);
      write_csr(CSR_GAIN_SINGLE, gs);
      write_csr(CSR_CHAN_COUNT, 16'(cnt));
      write_csr(CSR_BLOCK_LOG2, 16'(lg2));
      csr_valid <= 1'b0;
   endtask

   // Extremes, every command and the corner cases of ramps and channel counts
   task automatic test_directed_cases();
      // gains are still zero after reset
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MAX);
      send_item(CMD_PEAK, 3'd0, '0);
      send_item(CMD_SPARE_LO, 3'd1, SAMPLE_MIN);
      send_item(CMD_SPARE_HI, 3'd7, SAMPLE_MAX);
      send_item(CMD_SAMPLE, 3'd2, SAMPLE_MAX);
      // load inside a plain block applies at once; negative output keeps peak at zero
      send_item(CMD_LOAD, 3'd0, '0);
      send_item(CMD_SAMPLE, 3'd1, SAMPLE_MIN);
      send_item(CMD_PEAK, 3'd1, '0);
      wait_meter_idle();

      // one-sample ramp, paired and trailing channels, saturating gain
      configure_meter(16'hFFFF, 16'h0000, 16'h0001, 4'd3, 4'd0);
      send_item(CMD_END, 3'd0, '0);
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MAX);
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MAX);
      send_item(CMD_LOAD, 3'd0, '0);
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MAX);
      send_item(CMD_SAMPLE, 3'd2, -24'sd1);
      send_item(CMD_END, 3'd0, '0);
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MIN);
      send_item(CMD_SAMPLE, 3'd1, 24'sh123456);
      send_item(CMD_FADE, 3'd0, '0);
      send_item(CMD_PEAK, 3'd0, '0);
      wait_meter_idle();

      // no channel in use; unmapped register index
      write_csr(CSR_UNMAPPED, 16'hFFFF);
      configure_meter(16'h5555, 16'hAAAA, 16'h8001, 4'd0, 4'd15);
      send_item(CMD_SAMPLE, 3'd0, SAMPLE_MAX);
      send_item(CMD_PEAK, 3'd0, '0);
      wait_meter_idle();

      // count above the channel limit, ramp length above its limit
      configure_meter(16'h2000, 16'h6000, 16'hC000, 4'd15, 4'd13);
      send_item(CMD_LOAD, 3'd0, '0);
      send_item(CMD_END, 3'd0, '0);
      send_item(CMD_SAMPLE, 3'd7, 24'sh5A5A5A);
      send_item(CMD_SAMPLE, 3'd7, 24'shA5A5A5);
      send_item(CMD_SAMPLE, 3'd6, SAMPLE_MAX);
      send_item(CMD_PEAK, 3'd6, '0);
      wait_meter_idle();
   endtask

   // Stall the output long enough to fill the block, then drain it
   task automatic test_backpressure();
      int unsigned k;
      configure_meter(16'd20000, 16'd12000, GAIN_UNITY, 4'd8, 4'd2);
      req_max_gap   = 0;
      rsp_max_stall = 0;
      send_item(CMD_LOAD, 3'd0, '0);
      send_item(CMD_END, 3'd0, '0);
      hold_request = 64;
      for (k = 0; k < 24; k++) send_item(CMD_SAMPLE, k[CHAN_W-1:0], rand_sample());
      for (k = 0; k < 8; k++) send_item(CMD_PEAK, k[CHAN_W-1:0], '0);
      wait_meter_idle();
   endtask

   // One register setting, then blocks of samples with loads, fades and reads
   task automatic run_random_phase(int unsigned budget);
      int unsigned start, used, n, per_chan, k, pick;
      logic [CHAN_W-1:0] ch;
      wait_meter_idle();
      configure_meter(rand_gain(), rand_gain(), rand_gain(),
                      ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8)),
                      ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15))
                                                  : 4'($urandom_range(0, 4)));
      req_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      used = channels_in_use();
      n = 1 << ((cfg_log2 > RAMP_LOG2_MAX) ? RAMP_LOG2_MAX : cfg_log2);
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any code, any channel
            send_item(3'($urandom_range(CMD_SAMPLE, CMD_SPARE_HI)), 3'($urandom),
                      24'($urandom));
         end else begin
            pick = $urandom_range(0, 3);
            if (pick == 0) send_item(CMD_LOAD, 3'($urandom), 24'($urandom));
            else if (pick == 1) send_item(CMD_FADE, 3'($urandom), 24'($urandom));
            send_item(CMD_END, 3'($urandom), 24'($urandom));
            per_chan = ((n < 16) ? n : 16) + $urandom_range(0, 2);
            for (k = 0; k < used * per_chan; k++) begin
               ch = 3'($urandom_range(0, used - 1));
               pick = $urandom_range(0, 39);
               if (pick == 0) send_item(CMD_LOAD, ch, '0);
               else if (pick == 1) send_item(CMD_FADE, ch, '0);
               else if (pick < 5) send_item(CMD_PEAK, 3'($urandom), rand_sample());
               else send_item(CMD_SAMPLE, ch, rand_sample());
            end
            if ($urandom_range(0, 1) == 0)
               for (k = 0; k < used; k++) send_item(CMD_PEAK, k[CHAN_W-1:0], '0);
         end
      end
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) run_random_phase(150);
   endtask

   // Output side: random stall per transfer, or a long hold when asked
   initial begin : rsp_side
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = $urandom_range(0, rsp_max_stall);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && hold_request == 0);
      end
   end

   // Compare each output transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outputs.size() == 0) begin
            $error("output with nothing expected: sample_out %0d peak_out %0d",
                   rsp_sample_out, rsp_peak_out);
            failures++;
         end else begin
            oldest = awaited_outputs.pop_front();
            if (rsp_sample_out !== oldest.sample_out) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      oldest.sample_out, rsp_sample_out);
               failures++;
            end
            if (rsp_peak_out !== oldest.peak_out) begin
               $error("peak_out mismatch: expected %0d, actual %0d",
                      oldest.peak_out, rsp_peak_out);
               failures++;
            end
            outputs_checked++;
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout with %0d outputs outstanding", awaited_outputs.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_backpressure();
      test_random_traffic();
      wait_meter_idle();
      $display("checked %0d outputs from %0d requests, %0d register writes",
               outputs_checked, items_sent, csr_writes);
      $display("covered all commands, reserved codes, channel counts 0-15, ramps 1-4096");
      if (failures == 0 && awaited_outputs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/grpm_pkg.sv
design/grpm_csr.sv
design/grpm_front.sv
design/grpm_back.sv
design/gain_ramp_peak_meter.sv
design/grpm_checker.sv
dv/testbench.sv
